// ===== rtl/sdp_pkg.sv =====
package sdp_pkg;

  localparam int GRID_X = 256;
  localparam int GRID_Y = 256;
  localparam int GRID_Z = 256;

  localparam int COORD_W  = 8;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 3;

  localparam int GRID_XY  = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int GRID_MAX = (GRID_XY > GRID_Z) ? GRID_XY : GRID_Z;
  localparam int WAVE_REF = (GRID_MAX > (1 << COORD_W)) ? GRID_MAX : (1 << COORD_W);

  // wavenumber, its pairwise products, coefficient terms and their sum
  localparam int WAVE_W = $clog2(WAVE_REF) + 2;
  localparam int PROD_W = 2 * WAVE_W;
  localparam int TERM_W = DATA_W + 1 + PROD_W;
  localparam int SUM_W  = TERM_W + 3;
  localparam int MAG_W  = SUM_W;
  localparam int HI_W   = MAG_W - DATA_W;
  localparam int PM_W   = DATA_W + MAG_W;
  localparam int D_W    = PM_W + 1;
  localparam int DEN_W  = D_W + 1;

  // quotient bits resolved by the divider row; larger quotients saturate
  localparam int QBITS  = 34;
  localparam int REM_W  = DEN_W + QBITS;

  localparam int ONE_EXP = 42;
  localparam int NUM_EXP = 73;

  localparam logic [DATA_W-1:0] RECIP_ONE = 32'h4000_0000;
  localparam logic [DATA_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG   = 32'h8000_0000;

  typedef enum logic [IDX_W-1:0] {
    REG_TIME_STEP = 3'd0,
    REG_COEF_XX   = 3'd1,
    REG_COEF_XY   = 3'd2,
    REG_COEF_XZ   = 3'd3,
    REG_COEF_YY   = 3'd4,
    REG_COEF_YZ   = 3'd5,
    REG_COEF_ZZ   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic        [DATA_W-1:0] dt;
    logic signed [DATA_W-1:0] kxx;
    logic signed [DATA_W-1:0] kxy;
    logic signed [DATA_W-1:0] kxz;
    logic signed [DATA_W-1:0] kyy;
    logic signed [DATA_W-1:0] kyz;
    logic signed [DATA_W-1:0] kzz;
  } coef_t;

  typedef struct packed {
    logic             vld;
    logic             zero;
    logic             ovf;
    logic             neg;
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] dsh;
    logic [QBITS-1:0] quo;
  } div_t;

  function automatic logic signed [WAVE_W-1:0] wavenum(logic [COORD_W-1:0] c, int n);
    logic signed [WAVE_W-1:0] x;
    logic signed [WAVE_W-1:0] nn;
    logic signed [WAVE_W-1:0] x2;
    x  = WAVE_W'($signed({1'b0, c}));
    nn = WAVE_W'(n);
    x2 = x + x;
    if (x2 > nn) begin
      return x - nn;
    end else if (x2 == nn) begin
      return '0;
    end
    return x;
  endfunction

endpackage

// ===== rtl/sdp_div_cell.sv =====
module sdp_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  sdp_pkg::div_t prev_i,
  output sdp_pkg::div_t next_o
);
  import sdp_pkg::*;

  logic             vld_q;
  div_t             pay_q;
  div_t             pay_d;
  logic             take;

  always_comb begin
    pay_d = prev_i;
    take  = (prev_i.rem >= prev_i.dsh);
    if (take) begin
      pay_d.rem = prev_i.rem - prev_i.dsh;
    end
    pay_d.quo = {prev_i.quo[QBITS-2:0], take};
    pay_d.dsh = prev_i.dsh >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= prev_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    next_o     = pay_q;
    next_o.vld = vld_q;
  end

endmodule

// ===== rtl/sdp_front.sv =====
module sdp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [sdp_pkg::COORD_W-1:0]  coord_x_i,
  input  logic [sdp_pkg::COORD_W-1:0]  coord_y_i,
  input  logic [sdp_pkg::COORD_W-1:0]  coord_z_i,
  input  sdp_pkg::coef_t               coef_i,
  output sdp_pkg::div_t                div_o
);
  import sdp_pkg::*;

  localparam int NSTG = 10;

  logic [NSTG-1:0] vld_q;

  logic signed [WAVE_W-1:0] wx_q, wy_q, wz_q;
  logic signed [PROD_W-1:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q;
  logic signed [TERM_W-1:0] txx_q, tyy_q, tzz_q, txy_q, txz_q, tyz_q;
  logic signed [SUM_W-1:0]  sa_q, sb_q, sc_q, s_q;
  logic        [MAG_W-1:0]  mag_q;
  logic                     neg5_q, neg6_q, neg7_q;
  logic        [2*DATA_W-1:0]    plo_q;
  logic        [DATA_W+HI_W-1:0] phi_q;
  logic        [PM_W-1:0]        prod_q;
  logic        [D_W-1:0]         d_q, d_d;
  logic                          neg8_q, neg8_d;
  div_t                          div_q, div_d;
  logic        [D_W-1:0]         one_c, prod_x;
  logic        [REM_W-1:0]       num_c, den_c;

  always_comb begin
    one_c  = D_W'(1) << ONE_EXP;
    prod_x = D_W'(prod_q);
    neg8_d = 1'b0;
    if (!neg7_q) begin
      d_d = one_c + prod_x;
    end else if (one_c >= prod_x) begin
      d_d = one_c - prod_x;
    end else begin
      d_d    = prod_x - one_c;
      neg8_d = 1'b1;
    end
  end

  always_comb begin
    // round to nearest: floor((2^73 + D) / 2D)
    num_c      = (REM_W'(1) << NUM_EXP) + REM_W'(d_q);
    den_c      = REM_W'(d_q) << 1;
    div_d.vld  = 1'b0;
    div_d.zero = (d_q == '0);
    div_d.ovf  = (num_c >= (den_c << QBITS));
    div_d.neg  = neg8_q;
    div_d.rem  = num_c;
    div_d.dsh  = den_c << (QBITS - 1);
    div_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q   <= wavenum(coord_x_i, GRID_X);
      wy_q   <= wavenum(coord_y_i, GRID_Y);
      wz_q   <= wavenum(coord_z_i, GRID_Z);

      pxx_q  <= PROD_W'(wx_q) * PROD_W'(wx_q);
      pyy_q  <= PROD_W'(wy_q) * PROD_W'(wy_q);
      pzz_q  <= PROD_W'(wz_q) * PROD_W'(wz_q);
      pxy_q  <= PROD_W'(wx_q) * PROD_W'(wy_q);
      pxz_q  <= PROD_W'(wx_q) * PROD_W'(wz_q);
      pyz_q  <= PROD_W'(wy_q) * PROD_W'(wz_q);

      txx_q  <= TERM_W'(coef_i.kxx) * TERM_W'(pxx_q);
      tyy_q  <= TERM_W'(coef_i.kyy) * TERM_W'(pyy_q);
      tzz_q  <= TERM_W'(coef_i.kzz) * TERM_W'(pzz_q);
      txy_q  <= (TERM_W'(coef_i.kxy) * TERM_W'(pxy_q)) <<< 1;
      txz_q  <= (TERM_W'(coef_i.kxz) * TERM_W'(pxz_q)) <<< 1;
      tyz_q  <= (TERM_W'(coef_i.kyz) * TERM_W'(pyz_q)) <<< 1;

      sa_q   <= SUM_W'(txx_q) + SUM_W'(tyy_q);
      sb_q   <= SUM_W'(tzz_q) + SUM_W'(txy_q);
      sc_q   <= SUM_W'(txz_q) + SUM_W'(tyz_q);

      s_q    <= sa_q + sb_q + sc_q;

      neg5_q <= s_q[SUM_W-1];
      mag_q  <= s_q[SUM_W-1] ? MAG_W'(-s_q) : MAG_W'(s_q);

      // split dt * |S| into partial products over the low 32 bits and the high 24 bits of |S|
      neg6_q <= neg5_q;
      plo_q  <= (2*DATA_W)'(coef_i.dt) * (2*DATA_W)'(mag_q[DATA_W-1:0]);
      phi_q  <= (DATA_W+HI_W)'(coef_i.dt) * (DATA_W+HI_W)'(mag_q[MAG_W-1:DATA_W]);

      neg7_q <= neg6_q;
      prod_q <= PM_W'(plo_q) + (PM_W'(phi_q) << DATA_W);

      d_q    <= d_d;
      neg8_q <= neg8_d;

      div_q  <= div_d;
    end
  end

  always_comb begin
    div_o     = div_q;
    div_o.vld = vld_q[NSTG-1];
  end

endmodule

// ===== rtl/spectral_diffusion_precond_factor.sv =====
// channel   direction  handshake              payload
// in        sink       in_valid_i/in_stall_o  coord_x_i, coord_y_i, coord_z_i
// out       source     out_valid_o/out_stall_i recip_value_o, saturated_o
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One coordinate per cycle unless stalled; ten arithmetic stages, a row of
// 34 restoring-divider cells (one quotient bit each), and the output register.
// Reset clears all valid bits and the seven registers to zero.
// A stalled result freezes the whole pipeline; in_stall_o follows it.
module spectral_diffusion_precond_factor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sdp_pkg::COORD_W-1:0]   coord_x_i,
  input  logic [sdp_pkg::COORD_W-1:0]   coord_y_i,
  input  logic [sdp_pkg::COORD_W-1:0]   coord_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [sdp_pkg::DATA_W-1:0] recip_value_o,
  output logic                          saturated_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sdp_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [sdp_pkg::DATA_W-1:0]    cfg_data_i
);
  import sdp_pkg::*;

  coef_t              coef_q;
  logic               en;
  div_t               chain [QBITS+1];
  logic               out_valid_q;
  logic [DATA_W-1:0]  recip_q, recip_d;
  logic               sat_q, sat_d;
  div_t               last;
  logic [QBITS-1:0]   limit;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_TIME_STEP: coef_q.dt  <= cfg_data_i;
        REG_COEF_XX:   coef_q.kxx <= cfg_data_i;
        REG_COEF_XY:   coef_q.kxy <= cfg_data_i;
        REG_COEF_XZ:   coef_q.kxz <= cfg_data_i;
        REG_COEF_YY:   coef_q.kyy <= cfg_data_i;
        REG_COEF_YZ:   coef_q.kyz <= cfg_data_i;
        REG_COEF_ZZ:   coef_q.kzz <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sdp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (in_valid_i),
    .coord_x_i (coord_x_i),
    .coord_y_i (coord_y_i),
    .coord_z_i (coord_z_i),
    .coef_i    (coef_q),
    .div_o     (chain[0])
  );

  for (genvar g = 0; g < QBITS; g++) begin : g_cell
    sdp_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .prev_i (chain[g]),
      .next_o (chain[g+1])
    );
  end

  assign last = chain[QBITS];

  always_comb begin
    limit = last.neg ? QBITS'(SAT_NEG) : QBITS'(SAT_POS);
    sat_d = 1'b0;
    if (last.zero) begin
      recip_d = RECIP_ONE;
    end else if (last.ovf || (last.quo > limit)) begin
      recip_d = last.neg ? SAT_NEG : SAT_POS;
      sat_d   = 1'b1;
    end else if (last.neg) begin
      recip_d = -last.quo[DATA_W-1:0];
    end else begin
      recip_d = last.quo[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      recip_q <= recip_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign recip_value_o = $signed(recip_q);
  assign saturated_o   = sat_q;

endmodule
